### src/ssd_pkg.sv
`timescale 1ns / 1ps
package ssd_pkg;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned DefCountBits = 32;
  localparam int unsigned DefFracBits = 16;
  localparam int unsigned SampleW = 32;
  localparam int unsigned DevW = 48;
  localparam int unsigned SumW = 72;
  localparam int unsigned SqW = 128;

  typedef enum logic [2:0] {
    FmtU8 = 3'd0, FmtS8 = 3'd1, FmtU16 = 3'd2, FmtS16 = 3'd3, FmtU32 = 3'd4, FmtS32 = 3'd5
  } fmt_e;

  typedef enum logic [2:0] {
    StIdle, StMul, StDiv, StFrac, StSqrt, StOut
  } state_e;

  localparam logic [0:0] RegFormat = 1'b0;
endpackage

### src/ssd_if.sv
`timescale 1ns / 1ps
interface ssd_in_if;
  logic valid;
  logic ready;
  logic [31:0] sample_a;
  logic [31:0] sample_b;
  logic [31:0] sample_c;
  logic [31:0] sample_d;
  logic [2:0] valid_count;
  logic last_item;
  modport source (output valid, sample_a, sample_b, sample_c, sample_d, valid_count,
                  last_item, input ready);
  modport sink (input valid, sample_a, sample_b, sample_c, sample_d, valid_count,
                last_item, output ready);
endinterface

interface ssd_out_if;
  logic valid;
  logic ready;
  logic [47:0] deviation;
  logic [31:0] sample_total;
  logic too_few_samples;
  logic count_saturated;
  modport source (output valid, deviation, sample_total, too_few_samples, count_saturated,
                  input ready);
  modport sink (input valid, deviation, sample_total, too_few_samples, count_saturated,
                output ready);
endinterface

### src/sample_standard_deviation_core.sv
`timescale 1ns / 1ps
// Takes up to four samples per item, one lane each. A last item
// starts the finishing unit, which runs a multiply, a bit-serial division and
// a bit-serial square root, and input stays stalled from the last item's
// transfer until the result is transferred.
module sample_standard_deviation_core
  import ssd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = DefCountBits,
  parameter int unsigned FRAC_BITS = DefFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssd_in_if.sink      in_if,
  ssd_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [2:0] fmt_q;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [SqW-1:0] sq_q, sq_d;
  logic sat_q, sat_d;
  logic [31:0] raw [4];
  logic [SumW-1:0] lv [NumLanes];
  logic [63:0] lsq [NumLanes];
  logic out_v_q, pend_q, tot_few_q, tot_sat_q;
  logic [31:0] tot_q;
  logic busy, done, start;
  logic [DevW-1:0] dev;
  logic [2:0] vc;

  assign pready = 1'b1;
  assign prdata = {29'd0, fmt_q};
  assign raw[0] = in_if.sample_a;
  assign raw[1] = in_if.sample_b;
  assign raw[2] = in_if.sample_c;
  assign raw[3] = in_if.sample_d;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    ssd_lane u_lane (.fmt_i(fmt_q), .raw_i(raw[g]), .val_o(lv[g]), .sq_o(lsq[g]));
  end

  assign in_if.ready = !busy && !pend_q && !out_v_q;
  assign vc = (in_if.valid_count > 3'(NumLanes)) ? 3'(NumLanes) : in_if.valid_count;

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    sq_d = sq_q;
    sat_d = sat_q;
    for (int i = 0; i < NumLanes; i++) begin
      if (3'(i) < vc) begin
        if (cnt_d == CountMax) sat_d = 1'b1;
        else begin
          sum_d = sum_d + lv[i];
          sq_d = sq_d + SqW'(lsq[i]);
          cnt_d = cnt_d + 1'b1;
          if (cnt_d == CountMax) sat_d = 1'b1;
        end
      end
    end
  end

  assign start = in_if.valid && in_if.ready && in_if.last_item;

  ssd_finish #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_fin (
    .clk_i, .rst_ni, .start_i(pend_q), .n_i(cnt_q), .sum_i(sum_q), .sq_i(sq_q),
    .busy_o(busy), .done_o(done), .dev_o(dev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
      sq_q <= '0;
      sat_q <= 1'b0;
      pend_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[1:0] == 2'(RegFormat)) fmt_q <= pwdata[2:0];
      if (in_if.valid && in_if.ready) begin
        cnt_q <= cnt_d;
        sum_q <= sum_d;
        sq_q <= sq_d;
        sat_q <= sat_d;
      end
      if (start) pend_q <= 1'b1;
      else if (pend_q && busy) pend_q <= 1'b0;
      if (done) begin
        out_v_q <= 1'b1;
        cnt_q <= '0;
        sum_q <= '0;
        sq_q <= '0;
        sat_q <= 1'b0;
      end else if (out_if.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      tot_q <= 32'(cnt_d);
      tot_few_q <= cnt_d < 2;
      tot_sat_q <= sat_d;
    end
  end

  assign out_if.valid = out_v_q;
  assign out_if.deviation = dev;
  assign out_if.sample_total = tot_q;
  assign out_if.too_few_samples = tot_few_q;
  assign out_if.count_saturated = tot_sat_q;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_if.ready) else $error("accepted while busy");
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_if.valid) else $error("result lost");
`endif
endmodule

### src/ssd_lane.sv
`timescale 1ns / 1ps
module ssd_lane
  import ssd_pkg::*;
(
  input  logic [2:0]        fmt_i,
  input  logic [SampleW-1:0] raw_i,
  output logic [SumW-1:0]   val_o,
  output logic [63:0]       sq_o
);
  logic [32:0] v;
  logic [31:0] mag;

  always_comb begin
    case (fmt_i)
      FmtU8:   v = {25'd0, raw_i[7:0]};
      FmtS8:   v = {{25{raw_i[7]}}, raw_i[7:0]};
      FmtU16:  v = {17'd0, raw_i[15:0]};
      FmtS16:  v = {{17{raw_i[15]}}, raw_i[15:0]};
      FmtS32:  v = {raw_i[31], raw_i};
      default: v = {1'b0, raw_i};
    endcase
    mag = v[32] ? 32'(-v) : v[31:0];
  end

  assign val_o = {{(SumW-33){v[32]}}, v};
  assign sq_o  = 64'(mag) * 64'(mag);
endmodule

### src/ssd_finish.sv
`timescale 1ns / 1ps
module ssd_finish
  import ssd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = DefCountBits,
  parameter int unsigned FRAC_BITS = DefFracBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COUNT_BITS-1:0] n_i,
  input  logic [SumW-1:0]       sum_i,
  input  logic [SqW-1:0]        sq_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [DevW-1:0]       dev_o
);
  localparam int unsigned VarW = SqW + 2 * FRAC_BITS;
  localparam int unsigned RootW = (VarW + 1) / 2;
  localparam int unsigned DivW = 2 * COUNT_BITS + 1;

  state_e state_q, state_d;
  logic [7:0] cnt_q;
  logic [63:0] sabs_q;
  logic [SqW-1:0] sq_q;
  logic [COUNT_BITS-1:0] n_q;
  logic [SqW-1:0] ns2_q, s2_q;
  logic [2*COUNT_BITS-1:0] m_q;
  logic [SqW-1:0] num_q, quo_q;
  logic [DivW-1:0] rem_q;
  logic [VarW-1:0] x_q, root_q;
  logic [DivW-1:0] rtry;
  logic [SqW-1:0] diff;

  // Multiply in 32x32 partial products, one per cycle.
  logic [31:0] ma, mb;
  logic [63:0] mp;
  assign mp = 64'(ma) * 64'(mb);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (start_i) state_d = StMul;
      StMul:  if (cnt_q == 8'd8) state_d = StDiv;
      StDiv:  if (cnt_q == 8'(SqW - 1)) state_d = StFrac;
      StFrac: if (cnt_q == 8'(2 * FRAC_BITS)) state_d = StSqrt;
      StSqrt: if (cnt_q == 8'(RootW)) state_d = StOut;
      StOut:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    busy_o = (state_q != StIdle);
    done_o = (state_q == StOut);
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cnt_q[2:0])
      3'd0: begin ma = sabs_q[31:0];  mb = sabs_q[31:0]; end
      3'd1: begin ma = sabs_q[31:0];  mb = sabs_q[63:32]; end
      3'd2: begin ma = sabs_q[63:32]; mb = sabs_q[63:32]; end
      3'd3: begin ma = sq_q[31:0];    mb = 32'(n_q); end
      3'd4: begin ma = sq_q[63:32];   mb = 32'(n_q); end
      3'd5: begin ma = sq_q[95:64];   mb = 32'(n_q); end
      3'd6: begin ma = sq_q[127:96];  mb = 32'(n_q); end
      3'd7: begin ma = 32'(n_q);      mb = 32'(n_q - 1'b1); end
      default: ;
    endcase
    diff = (ns2_q >= s2_q) ? ns2_q - s2_q : s2_q - ns2_q;
    rtry = {rem_q[DivW-2:0], (state_q == StDiv) ? num_q[SqW-1] : 1'b0};
  end

  logic [VarW-1:0] one_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) cnt_q <= '0;
      else cnt_q <= cnt_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        // Operands are taken only at start so that the result stays stable
        // while it waits to be transferred.
        if (start_i) begin
          n_q <= n_i;
          sq_q <= sq_i;
          sabs_q <= sum_i[SumW-1] ? 64'(-sum_i) : 64'(sum_i);
          ns2_q <= '0;
          s2_q <= '0;
        end
      end
      StMul: begin
        unique case (cnt_q[3:0])
          4'd0: s2_q <= SqW'(mp);
          4'd1: s2_q <= s2_q + (SqW'(mp) << 33);
          4'd2: s2_q <= s2_q + (SqW'(mp) << 64);
          4'd3: ns2_q <= SqW'(mp);
          4'd4: ns2_q <= ns2_q + (SqW'(mp) << 32);
          4'd5: ns2_q <= ns2_q + (SqW'(mp) << 64);
          4'd6: ns2_q <= ns2_q + (SqW'(mp) << 96);
          4'd7: m_q <= (2*COUNT_BITS)'(mp);
          default: begin
            num_q <= diff;
            rem_q <= '0;
            quo_q <= '0;
          end
        endcase
      end
      StDiv, StFrac: begin
        num_q <= {num_q[SqW-2:0], 1'b0};
        if (rtry >= DivW'(m_q)) begin
          rem_q <= rtry - DivW'(m_q);
          quo_q <= {quo_q[SqW-2:0], 1'b1};
        end else begin
          rem_q <= rtry;
          quo_q <= {quo_q[SqW-2:0], 1'b0};
        end
        if (state_q == StFrac && cnt_q == 8'(2 * FRAC_BITS)) root_q <= '0;
        if (state_q == StDiv && cnt_q == 8'(SqW - 1)) x_q <= '0;
        if (state_q == StFrac && cnt_q == 8'd0) x_q <= VarW'(quo_q);
      end
      StSqrt: begin
        if (cnt_q == 8'd0) begin
          x_q <= (VarW'(x_q) << (2 * FRAC_BITS)) | VarW'(quo_q[2*FRAC_BITS:0] >> 1);
          one_q <= VarW'(1) << (2 * (RootW - 1));
        end else begin
          if ({2'b00, x_q} >= {2'b00, root_q} + {2'b00, one_q}) begin
            x_q <= x_q - root_q - one_q;
            root_q <= (root_q >> 1) + one_q;
          end else begin
            root_q <= root_q >> 1;
          end
          one_q <= one_q >> 2;
        end
      end
      default: ;
    endcase
  end

  assign dev_o = (n_q < 2) ? '0 : ((root_q >> DevW) != '0) ? {DevW{1'b1}} : root_q[DevW-1:0];
endmodule

### bench/ssd_checker.sv
`timescale 1ns / 1ps
module ssd_checker
  import ssd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ssd_in_if           in_mon,
  ssd_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned err_count_o,
  output int unsigned pending_o,
  output int unsigned results_o
);
  typedef struct packed {
    logic [47:0] deviation;
    logic [31:0] sample_total;
    logic        too_few_samples;
    logic        count_saturated;
  } dev_result_t;

  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;
  localparam logic [47:0] DevMax = 48'hFFFF_FFFF_FFFF;

  logic [2:0]          fmt_reg;
  logic [31:0]         n_seen;
  logic signed [71:0]  sum_acc;
  logic [127:0]        sq_acc;
  logic                sat_seen;
  dev_result_t         dev_queue[$];

  function automatic logic signed [71:0] decode_sample(logic [31:0] raw);
    case (fmt_e'(fmt_reg))
      FmtU8:   return 72'(raw[7:0]);
      FmtS8:   return 72'(signed'(raw[7:0]));
      FmtU16:  return 72'(raw[15:0]);
      FmtS16:  return 72'(signed'(raw[15:0]));
      FmtS32:  return 72'(signed'(raw));
      default: return 72'(raw);
    endcase
  endfunction

  function automatic logic [127:0] floor_sqrt(logic [127:0] x);
    logic [127:0] res;
    logic [127:0] bitv;
    logic [127:0] t;
    res = '0;
    bitv = 128'd1 << 126;
    while (bitv > x && bitv != 0) bitv = bitv >> 2;
    while (bitv != 0) begin
      t = res + bitv;
      if (x >= t) begin
        x = x - t;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic dev_result_t finish_stats();
    dev_result_t r;
    logic [71:0]  sabs;
    logic [127:0] s_sq, n_s2, diff, q, f, var_q, root;
    logic [63:0]  m, rem;
    r.deviation = '0;
    r.sample_total = n_seen;
    r.too_few_samples = (n_seen < 2);
    r.count_saturated = sat_seen;
    if (n_seen >= 2) begin
      sabs = (sum_acc < 0) ? -sum_acc : sum_acc;
      s_sq = 128'(sabs[63:0]) * 128'(sabs[63:0]);
      n_s2 = sq_acc * 128'(n_seen);
      diff = (n_s2 >= s_sq) ? n_s2 - s_sq : s_sq - n_s2;
      m = 64'(n_seen) * 64'(n_seen - 1);
      q = diff / 128'(m);
      rem = 64'(diff % 128'(m));
      f = (128'(rem) << (2 * DefFracBits)) / 128'(m);
      var_q = (q << (2 * DefFracBits)) + f;
      root = floor_sqrt(var_q);
      r.deviation = (root > 128'(DevMax)) ? DevMax : root[47:0];
    end
    return r;
  endfunction

  task automatic take_item();
    logic [31:0] lanes[4];
    logic signed [71:0] v;
    logic [63:0] mag;
    int unsigned vc;
    lanes = '{in_mon.sample_a, in_mon.sample_b, in_mon.sample_c, in_mon.sample_d};
    vc = (in_mon.valid_count > NumLanes) ? NumLanes : in_mon.valid_count;
    for (int i = 0; i < vc; i++) begin
      if (n_seen == CountMax) begin
        sat_seen = 1'b1;
        break;
      end
      v = decode_sample(lanes[i]);
      mag = (v < 0) ? 64'(-v) : 64'(v);
      sum_acc = sum_acc + v;
      sq_acc = sq_acc + 128'(mag) * 128'(mag);
      n_seen = n_seen + 1;
      if (n_seen == CountMax) sat_seen = 1'b1;
    end
    if (in_mon.last_item) begin
      dev_queue.push_back(finish_stats());
      n_seen = '0;
      sum_acc = '0;
      sq_acc = '0;
      sat_seen = 1'b0;
    end
  endtask

  task automatic note_error(string what, dev_result_t exp_r, dev_result_t act_r);
    err_count_o++;
    if (err_count_o <= 10)
      $display("%0t: %s: expected dev=%h n=%0d few=%b sat=%b, got dev=%h n=%0d few=%b sat=%b",
               $time, what, exp_r.deviation, exp_r.sample_total, exp_r.too_few_samples,
               exp_r.count_saturated, act_r.deviation, act_r.sample_total,
               act_r.too_few_samples, act_r.count_saturated);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dev_result_t got;
    dev_result_t want;
    if (!rst_ni) begin
      fmt_reg = FmtU8;
      n_seen = '0;
      sum_acc = '0;
      sq_acc = '0;
      sat_seen = 1'b0;
      dev_queue.delete();
      err_count_o = 0;
      results_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.deviation, out_mon.sample_total, out_mon.too_few_samples,
                out_mon.count_saturated};
        results_o++;
        if (dev_queue.size() == 0) begin
          note_error("unexpected result", '0, got);
        end else begin
          want = dev_queue.pop_front();
          if (got != want) note_error("result mismatch", want, got);
        end
      end
      if (in_mon.valid && in_mon.ready) take_item();
      // A format write takes effect for items after this edge.
      if (psel && penable && pwrite && pready && paddr == 2'(4 * RegFormat))
        fmt_reg = pwdata[2:0];
    end
    pending_o = dev_queue.size();
  end
endmodule

### bench/tb_sample_standard_deviation_core.sv
`timescale 1ns / 1ps
module tb_sample_standard_deviation_core;
  import ssd_pkg::*;

  localparam int unsigned SettleCycles = 300;
  localparam int unsigned CycleLimit = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  int unsigned chk_errors, chk_pending, chk_results;
  int unsigned cycle_count;
  int unsigned gap_pct, stall_pct;
  int unsigned items_sent;

  ssd_in_if  in_ch();
  ssd_out_if out_ch();

  sample_standard_deviation_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_ch.sink), .out_if(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ssd_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch), .out_mon(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .err_count_o(chk_errors),
    .pending_o(chk_pending), .results_o(chk_results)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk_i) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  task automatic write_format(logic [2:0] fmt);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'(4 * RegFormat);
    pwdata <= 32'(fmt);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Config writes happen only with nothing in flight; this drops valid and waits
  // until every expected result has been taken.
  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (chk_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_item(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d,
                           logic [2:0] vc, logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_a <= a;
    in_ch.sample_b <= b;
    in_ch.sample_c <= c;
    in_ch.sample_d <= d;
    in_ch.valid_count <= vc;
    in_ch.last_item <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] corner[8] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h80, 32'h7F, 32'h8000, 32'h7FFF};
    if ($urandom_range(3) == 0) return corner[$urandom_range(7)];
    return $urandom();
  endfunction

  initial begin
    logic [2:0] phase_fmt[8];
    logic [2:0] vc;
    logic last;
    bit drain_each;
    phase_fmt = '{FmtU8, FmtS8, FmtU16, FmtS16, FmtU32, FmtS32, 3'd6, 3'd7};
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_a = '0;
    in_ch.sample_b = '0;
    in_ch.sample_c = '0;
    in_ch.sample_d = '0;
    in_ch.valid_count = '0;
    in_ch.last_item = 1'b0;
    out_ch.ready = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty and single-sample results, corner values per format,
    // an over-range lane count, and a u32/s32 mix within one accumulation.
    send_item(32'h0, 32'h0, 32'h0, 32'h0, 3'd0, 1'b1);
    send_item(32'h12, 32'h0, 32'h0, 32'h0, 3'd1, 1'b1);
    send_item(32'hFF, 32'h0, 32'h80, 32'h7F, 3'd4, 1'b0);
    send_item(32'hFFFF_FF01, 32'h0, 32'h0, 32'h0, 3'd2, 1'b1);
    wait_idle();
    write_format(FmtS8);
    send_item(32'h80, 32'h7F, 32'hFF, 32'h01, 3'd4, 1'b1);
    wait_idle();
    write_format(FmtU16);
    send_item(32'hFFFF, 32'h0, 32'h8000, 32'h7FFF, 3'd7, 1'b1);
    wait_idle();
    write_format(FmtS16);
    send_item(32'h8000, 32'h7FFF, 32'hFFFF, 32'h1, 3'd5, 1'b1);
    wait_idle();
    write_format(FmtU32);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 3'd4, 1'b0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 1'b0);
    wait_idle();
    write_format(FmtS32);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 3'd4, 1'b0);
    send_item(32'h8000_0000, 32'h0, 32'h0, 32'h0, 3'd6, 1'b1);
    send_item(32'h5, 32'h5, 32'h5, 32'h5, 3'd4, 1'b1);
    wait_idle();
    write_format(3'd6);
    send_item(32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0, 3'd3, 1'b1);
    wait_idle();
    write_format(3'd7);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 3'd2, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_format(phase_fmt[ph]);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 58; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 58; end
        default: begin gap_pct = 11; stall_pct = 11; end
      endcase
      drain_each = (ph == 2);
      for (int k = 0; k < 75; k++) begin
        vc = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
        last = ($urandom_range(7) == 0) || k == 74;
        send_item(pick_sample(), pick_sample(), pick_sample(), pick_sample(), vc, last);
        // Hold the sender back until the finishing unit has handed its result over.
        if (drain_each && last) begin
          @(negedge clk_i);
          in_ch.valid <= 1'b0;
          while (chk_pending != 0) @(negedge clk_i);
        end
      end
    end

    wait_idle();
    $display("Sent %0d items over all eight sample formats; %0d results checked.",
             items_sent, chk_results);
    $display("Phases covered free flow, sender gaps, receiver stalls and both at once.");
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", chk_errors, chk_pending);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
